### rtl/core/vrm_pkg.sv
// Shared types and constants for the vector rotate / magnitude unit.
`timescale 1ns / 1ps
`default_nettype none

package vrm_pkg;

	// Field widths
	localparam int FIELD_BITS = 16;
	localparam int ANG_BITS   = 15;          // reduced angle, 0 .. 23039

	// Angle units: 1/64 degree on the port, 2^-22 degree inside the CORDIC
	localparam int HALF_TURN_DEG   = 180;
	localparam int UNITS_PER_DEG   = 64;
	localparam int FULL_TURN_UNITS = 2 * HALF_TURN_DEG * UNITS_PER_DEG;
	localparam int HALF_TURN_UNITS = HALF_TURN_DEG * UNITS_PER_DEG;
	localparam int QUARTER_UNITS   = HALF_TURN_UNITS / 2;
	localparam int THREEQ_UNITS    = 3 * QUARTER_UNITS;
	localparam int ANGLE_SHIFT     = 16;     // 2^22 / 64

	// Datapath widths
	localparam int GUARD_BITS = 14;
	localparam int XW         = 32;          // coordinate accumulators
	localparam int ZW         = 32;          // angle accumulator
	localparam int PW         = 64;          // gain-correction product
	localparam int SW         = 20;          // scaled result before clamp

	// Gain correction: multiply by GAIN_INV / 2^30, then drop guard bits
	localparam logic signed [XW-1:0] GAIN_INV = 32'sd652032874;
	localparam int GAIN_SHIFT = 30;
	localparam int OUT_SHIFT  = GAIN_SHIFT + GUARD_BITS;
	localparam logic signed [PW-1:0] ROUND_HALF = 64'sd1 <<< (OUT_SHIFT - 1);

	// Arctangent of 2^-i in 2^-22 degree
	localparam int TABLE_LEN = 24;
	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
		32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
		32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
		32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
		32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
		32'sd229,       32'sd115,       32'sd57,       32'sd29
	};

	// State of one CORDIC stage: rotation path and vectoring path
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [XW-1:0] vx;
		logic signed [XW-1:0] vy;
	} cord_t;

endpackage

`default_nettype wire

### rtl/core/vector_rotate_magnitude_unit.sv
// Pipelined CORDIC unit: rotates a Q8.8 vector and measures its length.
//
// channel | signals                              | direction
// --------+--------------------------------------+----------
// in      | in_valid, in_ready, vec_x, vec_y,    | input
//         | turn_angle                           |
// out     | out_valid, out_ready, rot_x, rot_y,  | output
//         | magnitude, clipped                   |
//
// One item per cycle while out_ready stays high; the stages are angle reduction,
// quadrant fold, one stage per CORDIC step (up to TABLE_LEN), gain multiply, round and clamp.
// arst_n clears every stage valid bit; payload registers are not reset.
// Each stage holds only while it is full and the stage after it is held, so
// bubbles close up under a stall and no transfer is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module vector_rotate_magnitude_unit
	import vrm_pkg::*;
#(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_BITS   = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [FIELD_BITS-1:0] vec_x,
	input  wire logic signed [FIELD_BITS-1:0] vec_y,
	input  wire logic signed [FIELD_BITS-1:0] turn_angle,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [FIELD_BITS-1:0]      rot_x,
	output logic signed [FIELD_BITS-1:0]      rot_y,
	output logic        [FIELD_BITS-1:0]      magnitude,
	output logic                              clipped
);

	localparam int USED_STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int SAT_BITS   = (COORD_BITS > FIELD_BITS) ? FIELD_BITS : COORD_BITS;
	localparam logic signed [SW-1:0] SAT_HI  = SW'((64'sd1 <<< (SAT_BITS - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO  = -SAT_HI - SW'(1);
	localparam logic signed [SW-1:0] MAG_MAX = SW'(65535);

	// Stage valids and advance enables
	logic                  v_s1, v_s2, v_sm, v_so;
	logic [USED_STEPS-1:0] v_cs;
	logic                  adv_s1, adv_s2, adv_sm, adv_so;
	logic [USED_STEPS-1:0] adv_cs;

	// Stage payloads
	logic signed [FIELD_BITS-1:0] x0_s1, y0_s1;
	logic        [ANG_BITS-1:0]   ang_s1;
	cord_t                        cord_s2;
	cord_t                        cord_cs [USED_STEPS];
	logic signed [PW-1:0]         prod_x_sm, prod_y_sm, prod_m_sm;
	logic signed [FIELD_BITS-1:0] rot_x_so, rot_y_so;
	logic        [FIELD_BITS-1:0] mag_so;
	logic                         clip_so;

	// Ready chain, back to front
	assign adv_so = !v_so || out_ready;
	assign adv_sm = !v_sm || adv_so;
	assign adv_cs[USED_STEPS-1] = !v_cs[USED_STEPS-1] || adv_sm;
	for (genvar k = 0; k < USED_STEPS - 1; k++) begin : g_adv
		assign adv_cs[k] = !v_cs[k] || adv_cs[k+1];
	end
	assign adv_s2   = !v_s2 || adv_cs[0];
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Stage 1: reduce angle into [0, 360) degrees
	logic signed [ANG_BITS+2:0] t_w, ang_d;
	always_comb begin
		t_w = (ANG_BITS+3)'(turn_angle);
		if (t_w < -(ANG_BITS+3)'(FULL_TURN_UNITS)) begin
			ang_d = t_w + (ANG_BITS+3)'(2 * FULL_TURN_UNITS);
		end else if (t_w < 0) begin
			ang_d = t_w + (ANG_BITS+3)'(FULL_TURN_UNITS);
		end else if (t_w >= (ANG_BITS+3)'(FULL_TURN_UNITS)) begin
			ang_d = t_w - (ANG_BITS+3)'(FULL_TURN_UNITS);
		end else begin
			ang_d = t_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			x0_s1  <= vec_x;
			y0_s1  <= vec_y;
			ang_s1 <= ang_d[ANG_BITS-1:0];
		end
	end

	// Stage 2: fold into [-90, 90] degrees, widen coordinates
	logic signed [XW-1:0]       xe, ye;
	logic signed [ANG_BITS+1:0] ang_w, za;
	cord_t                      cord_d;
	always_comb begin
		xe    = XW'(x0_s1) <<< GUARD_BITS;
		ye    = XW'(y0_s1) <<< GUARD_BITS;
		ang_w = (ANG_BITS+2)'(signed'({1'b0, ang_s1}));
		cord_d.x  = xe;
		cord_d.y  = ye;
		za        = ang_w;
		if (ang_w > (ANG_BITS+2)'(QUARTER_UNITS) && ang_w < (ANG_BITS+2)'(THREEQ_UNITS)) begin
			cord_d.x = -xe;
			cord_d.y = -ye;
			za       = ang_w - (ANG_BITS+2)'(HALF_TURN_UNITS);
		end else if (ang_w >= (ANG_BITS+2)'(THREEQ_UNITS)) begin
			za = ang_w - (ANG_BITS+2)'(FULL_TURN_UNITS);
		end
		cord_d.z = ZW'(za) <<< ANGLE_SHIFT;
		// vectoring starts in the right half plane
		if (xe < 0) begin
			cord_d.vx = -xe;
			cord_d.vy = -ye;
		end else begin
			cord_d.vx = xe;
			cord_d.vy = ye;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cord_s2 <= cord_d;
		end
	end

	// CORDIC steps, one register stage each
	for (genvar k = 0; k < USED_STEPS; k++) begin : g_step
		cord_t c_in, c_out;
		logic  rot_pos, vec_pos;
		if (k == 0) begin : g_first
			assign c_in = cord_s2;
		end else begin : g_next
			assign c_in = cord_cs[k-1];
		end
		always_comb begin
			rot_pos = !c_in.z[ZW-1];
			vec_pos = !c_in.vy[XW-1];
			if (rot_pos) begin
				c_out.x = c_in.x - (c_in.y >>> k);
				c_out.y = c_in.y + (c_in.x >>> k);
				c_out.z = c_in.z - ATAN_TAB[k];
			end else begin
				c_out.x = c_in.x + (c_in.y >>> k);
				c_out.y = c_in.y - (c_in.x >>> k);
				c_out.z = c_in.z + ATAN_TAB[k];
			end
			if (vec_pos) begin
				c_out.vx = c_in.vx + (c_in.vy >>> k);
				c_out.vy = c_in.vy - (c_in.vx >>> k);
			end else begin
				c_out.vx = c_in.vx - (c_in.vy >>> k);
				c_out.vy = c_in.vy + (c_in.vx >>> k);
			end
		end
		always_ff @(posedge clk) begin
			if (adv_cs[k]) begin
				cord_cs[k] <= c_out;
			end
		end
	end

	// Gain correction products
	always_ff @(posedge clk) begin
		if (adv_sm) begin
			prod_x_sm <= cord_cs[USED_STEPS-1].x * GAIN_INV;
			prod_y_sm <= cord_cs[USED_STEPS-1].y * GAIN_INV;
			prod_m_sm <= cord_cs[USED_STEPS-1].vx * GAIN_INV;
		end
	end

	// Round back to Q8.8 and clamp
	logic signed [SW-1:0]         sx, sy, sm;
	logic signed [FIELD_BITS-1:0] cx, cy;
	logic        [FIELD_BITS-1:0] cm;
	logic                         hit_x, hit_y;
	always_comb begin
		sx = SW'((prod_x_sm + ROUND_HALF) >>> OUT_SHIFT);
		sy = SW'((prod_y_sm + ROUND_HALF) >>> OUT_SHIFT);
		sm = SW'((prod_m_sm + ROUND_HALF) >>> OUT_SHIFT);
		hit_x = 1'b0;
		hit_y = 1'b0;
		cx    = sx[FIELD_BITS-1:0];
		cy    = sy[FIELD_BITS-1:0];
		if (sx > SAT_HI) begin
			cx = SAT_HI[FIELD_BITS-1:0]; hit_x = 1'b1;
		end else if (sx < SAT_LO) begin
			cx = SAT_LO[FIELD_BITS-1:0]; hit_x = 1'b1;
		end
		if (sy > SAT_HI) begin
			cy = SAT_HI[FIELD_BITS-1:0]; hit_y = 1'b1;
		end else if (sy < SAT_LO) begin
			cy = SAT_LO[FIELD_BITS-1:0]; hit_y = 1'b1;
		end
		if (sm < 0) begin
			cm = '0;
		end else if (sm > MAG_MAX) begin
			cm = MAG_MAX[FIELD_BITS-1:0];
		end else begin
			cm = sm[FIELD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_so) begin
			rot_x_so <= cx;
			rot_y_so <= cy;
			mag_so   <= cm;
			clip_so  <= hit_x || hit_y;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_cs <= '0;
			v_sm <= 1'b0;
			v_so <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_cs[0]) v_cs[0] <= v_s2;
			for (int k = 1; k < USED_STEPS; k++) begin
				if (adv_cs[k]) v_cs[k] <= v_cs[k-1];
			end
			if (adv_sm) v_sm <= v_cs[USED_STEPS-1];
			if (adv_so) v_so <= v_sm;
		end
	end

	assign out_valid = v_so;
	assign rot_x     = rot_x_so;
	assign rot_y     = rot_y_so;
	assign magnitude = mag_so;
	assign clipped   = clip_so;

endmodule

`default_nettype wire
